// ===== rtl/core/lspe_pkg.sv =====
// Shared constants and types of the LED strip pattern engine.
package lspe_pkg;
  localparam int NUM_PIXELS_DEF = 32;

  localparam logic [3:0] MODE_NONE  = 4'd0;
  localparam logic [3:0] MODE_IDLE  = 4'd1;
  localparam logic [3:0] MODE_CHASE = 4'd2;
  localparam logic [3:0] MODE_WIPE  = 4'd3;
  localparam logic [3:0] MODE_FADE  = 4'd4;
  localparam logic [3:0] MODE_ELLIP = 4'd5;
  localparam logic [3:0] MODE_PULSE = 4'd6;
  localparam logic [3:0] MODE_SOLID = 4'd7;
  localparam logic [3:0] MODE_WEDGE = 4'd8;
  localparam logic [3:0] MODE_SMILE = 4'd9;
  localparam logic [3:0] MODE_LEFT  = 4'd10;
  localparam logic [3:0] MODE_RIGHT = 4'd11;
  localparam logic [3:0] MODE_UP    = 4'd12;
  localparam logic [3:0] MODE_DOWN  = 4'd13;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_INTERVAL = 3'd1;
  localparam logic [2:0] REG_STEPS    = 3'd2;
  localparam logic [2:0] REG_C1       = 3'd3;
  localparam logic [2:0] REG_C2       = 3'd4;
  localparam logic [2:0] REG_C3       = 3'd5;
  localparam logic [2:0] REG_AREV     = 3'd6;
  localparam logic [2:0] REG_SDIR     = 3'd7;

  // Divider request/response between top and divider.
  typedef struct packed {
    logic        start;
    logic [23:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] quo;
  } div_rsp_t;
endpackage

// ===== rtl/core/lspe_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module lspe_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lspe_pkg::div_req_t req,
  output lspe_pkg::div_rsp_t rsp
);
  import lspe_pkg::*;

  logic [23:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  // One shift-subtract step per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[15:0], quo_r[23]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[22:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

// ===== rtl/core/led_strip_pattern_engine_unit.sv =====
// Top level of the LED strip pattern engine: sequencer, pixel store, output.
//
//  channel | signals                               | direction
//  in      | in_valid, in_stall, in_now_ms         | in
//  out     | out_valid, out_stall, out_pixel_*     | out
//  cfg     | cfg_valid, cfg_ready, cfg_index/data  | in
//
// A tick that triggers a frame runs three serial divides in fade mode (24
// steps each), then renders one pixel per cycle and beats out one pixel per
// cycle while out_stall is low; other modes skip the divides. A tick that
// triggers nothing goes from the check state straight back to idle. Reset
// is synchronous; after it the pixel store reads zero through per-pixel
// valid bits. Output stall holds the emit sequencer at its pixel.
module led_strip_pattern_engine_unit #(
  parameter int NUM_PIXELS = lspe_pkg::NUM_PIXELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_pixel_index,
  output logic [23:0] out_pixel_color,
  output logic [7:0]  out_brightness,
  output logic        out_last_pixel,
  output logic        out_cycle_complete,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import lspe_pkg::*;

  localparam int PW = $clog2(NUM_PIXELS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_RENDER = 3'd3;
  localparam logic [2:0] S_ADV    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  mode_r;
  logic [15:0] interval_r, steps_r;
  logic [23:0] c1_r, c2_r, c3_r;
  logic        arev_r, sdir_r;
  logic [15:0] idx_r, idx_nxt;
  logic        rev_r, rev_nxt;
  logic [31:0] last_r, now_r;
  logic [7:0]  bright_r;
  logic        done_r, done_nxt;
  logic [PW-1:0] pix_r, pix_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [23:0] fade_r;
  logic [23:0] store_r [NUM_PIXELS];
  logic [NUM_PIXELS-1:0] vld_r;
  logic        wr_en;
  logic [23:0] wr_data;
  logic [23:0] rd_r;
  logic        ov_r, ov_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  lspe_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);

  // Divider operands for the channel whose divide starts this cycle.
  logic [15:0] t_eff, k_eff;
  logic [7:0]  a_ch, b_ch;
  logic [1:0]  ch_sel;
  always_comb begin
    t_eff = (steps_r == 16'd0) ? 16'd1 : steps_r;
    k_eff = (idx_r > t_eff) ? t_eff : idx_r;
    if (state_r == S_CHECK) begin
      ch_sel = 2'd0;
    end else if (state_r == S_DIV && drsp.done) begin
      ch_sel = 2'(ch_r + 2'd1);
    end else begin
      ch_sel = ch_r;
    end
    unique case (ch_sel)
      2'd0:    begin a_ch = c1_r[23:16]; b_ch = c2_r[23:16]; end
      2'd1:    begin a_ch = c1_r[15:8];  b_ch = c2_r[15:8];  end
      default: begin a_ch = c1_r[7:0];   b_ch = c2_r[7:0];   end
    endcase
  end
  logic [23:0] blend_num;
  assign blend_num = ({16'd0, a_ch} * {8'd0, 16'(t_eff - k_eff)}) +
                     ({16'd0, b_ch} * {8'd0, k_eff});

  // Pattern color for the pixel under render.
  logic [5:0]  p6;
  logic [23:0] pat;
  logic        pat_wr;
  logic [3:0]  e0, e1, e2;
  always_comb begin
    p6  = 6'(pix_r);
    e0  = idx_r[3:0];
    e1  = 4'(idx_r[3:0] + 4'd1);
    e2  = 4'(idx_r[3:0] + 4'd2);
    pat = c2_r;
    pat_wr = 1'b1;
    unique case (mode_r)
      MODE_NONE:  pat = '0;
      MODE_IDLE:  pat = (p6 == 6'd0) ? c1_r : 24'd0;
      MODE_CHASE: pat = (p6[0] ^ idx_r[0]) ? c2_r : c1_r;
      MODE_WIPE: begin
        pat = c1_r;
        pat_wr = (idx_r == {10'd0, p6});
      end
      MODE_FADE:  pat = fade_r;
      MODE_ELLIP: pat = (p6[5:4] == 2'd0 &&
                         (p6[3:0] == e0 || p6[3:0] == e1 || p6[3:0] == e2))
                        ? c1_r : c2_r;
      MODE_PULSE, MODE_SOLID: pat = c1_r;
      MODE_WEDGE: pat = (((p6 == 6'd2 || p6 == 6'd14) && idx_r > 16'd6) ||
                         ((p6 == 6'd1 || p6 == 6'd15) && idx_r > 16'd4) ||
                         (p6 == 6'd0 && idx_r > 16'd2)) ? c1_r : c2_r;
      MODE_SMILE: pat = (p6 == 6'd18 || p6 == 6'd26) ? c1_r :
                        (p6 >= 6'd20 && p6 <= 6'd24) ? c2_r : c3_r;
      MODE_LEFT:  pat = (p6 >= 6'd3 && p6 <= 6'd5) ? c1_r : c2_r;
      MODE_RIGHT: pat = (p6 >= 6'd11 && p6 <= 6'd13) ? c1_r : c2_r;
      MODE_UP:    pat = (p6 == 6'd0 || p6 == 6'd1 || p6 == 6'd15) ? c1_r : c2_r;
      MODE_DOWN:  pat = (p6 >= 6'd7 && p6 <= 6'd9) ? c1_r : c2_r;
      default:    pat_wr = 1'b0;
    endcase
  end

  // Index advance.
  logic [15:0] fwd, bwd;
  logic        adv_done;
  logic [15:0] adv_idx;
  logic        adv_rev;
  always_comb begin
    fwd = idx_r + 16'd1;
    bwd = idx_r - 16'd1;
    adv_done = 1'b0;
    adv_idx  = fwd;
    adv_rev  = rev_r;
    if (!rev_r) begin
      if (fwd >= steps_r) begin
        if (arev_r) begin
          adv_rev = 1'b1;
          adv_idx = steps_r - 16'd1;
        end else begin
          adv_idx  = '0;
          adv_done = 1'b1;
        end
      end
    end else begin
      adv_idx = bwd;
      if (bwd == 16'd0) begin
        if (arev_r) begin
          adv_rev = 1'b0;
        end else begin
          adv_idx  = steps_r - 16'd1;
          adv_done = 1'b1;
        end
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    rev_nxt   = rev_r;
    done_nxt  = done_r;
    pix_nxt   = pix_r;
    ch_nxt    = ch_r;
    ov_nxt    = ov_r;
    wr_en     = 1'b0;
    wr_data   = pat;
    dreq.start = 1'b0;
    dreq.num   = blend_num;
    dreq.den   = t_eff;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (32'(now_r - last_r) <= {16'd0, interval_r}) begin
          state_nxt = S_IDLE;
        end else if (mode_r > MODE_DOWN) begin
          state_nxt = S_IDLE;
        end else if (mode_r == MODE_FADE) begin
          ch_nxt = 2'd0;
          dreq.start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          pix_nxt = '0;
          state_nxt = S_RENDER;
        end
      end
      S_DIV: if (drsp.done) begin
        if (ch_r == 2'd2) begin
          pix_nxt = '0;
          state_nxt = S_RENDER;
        end else begin
          ch_nxt = ch_r + 2'd1;
          state_nxt = S_DIV;
        end
      end
      S_RENDER: begin
        wr_en = pat_wr;
        if (pix_r == PW'(NUM_PIXELS - 1)) begin
          state_nxt = S_ADV;
        end else begin
          pix_nxt = pix_r + PW'(1);
        end
      end
      S_ADV: begin
        idx_nxt  = adv_idx;
        rev_nxt  = adv_rev;
        done_nxt = adv_done;
        pix_nxt  = '0;
        ov_nxt   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: if (!out_stall) begin
        if (pix_r == PW'(NUM_PIXELS - 1)) begin
          ov_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          pix_nxt = pix_r + PW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // Divider restart on the next channel.
    if (state_r == S_DIV && drsp.done && ch_r != 2'd2) dreq.start = 1'b1;
  end

  logic [1:0] ch_cur;
  assign ch_cur = ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mode_r     <= MODE_NONE;
      interval_r <= 16'd100;
      steps_r    <= 16'd10;
      c1_r <= '0; c2_r <= '0; c3_r <= '0;
      arev_r <= 1'b0; sdir_r <= 1'b0;
      idx_r  <= '0; rev_r <= 1'b0;
      last_r <= '0; bright_r <= '0;
      done_r <= 1'b0; pix_r <= '0; ch_r <= '0;
      vld_r  <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      rev_r   <= rev_nxt;
      done_r  <= done_nxt;
      pix_r   <= pix_nxt;
      ch_r    <= ch_nxt;
      ov_r    <= ov_nxt;
      if (state_r == S_CHECK && 32'(now_r - last_r) > {16'd0, interval_r}) begin
        last_r <= now_r;
        if (mode_r == MODE_PULSE) bright_r <= 8'(8'd20 * (idx_r[7:0] + 8'd1));
      end
      if (wr_en) vld_r[pix_r] <= 1'b1;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MODE: begin
            mode_r <= cfg_data[3:0];
            idx_r  <= '0;
            rev_r  <= sdir_r;
          end
          REG_INTERVAL: interval_r <= cfg_data[15:0];
          REG_STEPS:    steps_r    <= cfg_data[15:0];
          REG_C1:       c1_r       <= cfg_data;
          REG_C2:       c2_r       <= cfg_data;
          REG_C3:       c3_r       <= cfg_data;
          REG_AREV:     arev_r     <= cfg_data[0];
          REG_SDIR:     sdir_r     <= cfg_data[0];
          default: ;
        endcase
      end
    end
    if (state_r == S_IDLE && in_valid) now_r <= in_now_ms;
    if (wr_en) store_r[pix_r] <= wr_data;
    // Registered store read at the pixel that is shown next.
    rd_r <= vld_r[pix_nxt] ? store_r[pix_nxt] : 24'd0;
    if (state_r == S_DIV && drsp.done) begin
      unique case (ch_cur)
        2'd0:    fade_r[23:16] <= drsp.quo[7:0];
        2'd1:    fade_r[15:8]  <= drsp.quo[7:0];
        default: fade_r[7:0]   <= drsp.quo[7:0];
      endcase
    end
  end

  // Result beat.
  assign out_valid          = ov_r;
  assign out_pixel_index    = 6'(pix_r);
  assign out_pixel_color    = rd_r;
  assign out_brightness     = bright_r;
  assign out_last_pixel     = (pix_r == PW'(NUM_PIXELS - 1));
  assign out_cycle_complete = done_r;

  // Checks.
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open during emit");
  a_last_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_pixel) |=> !out_valid)
    else $error("valid after last pixel");
  a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_pixel_index))
    else $error("pixel moved under stall");
endmodule
